@@ src/hcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Hip compliance correction package
// Shared widths, register codes, reset values and lane control types.
// ----------------------------------------------------------------------------
package hcc_pkg;

  localparam int TORQUE_W   = 24;  // Q15.8 torque
  localparam int STIFF_W    = 24;  // Q16.8 stiffness
  localparam int ANGLE_W    = 24;  // Q3.20 correction
  localparam int ALPHA_W    = 16;  // Q0.16 filter weight
  localparam int LIMIT_W    = 23;  // Q3.20 limit and step
  localparam int FRAC_SHIFT = 20;  // angle fraction bits
  localparam int DIVIDEND_W = TORQUE_W + FRAC_SHIFT;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LIMIT_W;

  localparam int WARMUP_DEFAULT = 5;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(65123);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10486);
  localparam logic [LIMIT_W-1:0] STEP_RESET  = LIMIT_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 2'd0,
    REG_LIMIT = 2'd1,
    REG_STEP  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [LIMIT_W-1:0] limit;
    logic [LIMIT_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic bypass;
    logic active;
  } lane_ctl_t;

  typedef struct packed {
    logic                       done;
    logic signed [TORQUE_W-1:0] filtered;
    logic signed [ANGLE_W-1:0]  correction;
  } lane_res_t;

endpackage

@@ src/hcc_req_if.sv @@
// ----------------------------------------------------------------------------
// Hip compliance request channel
// Valid/ready channel carrying torques, stiffness values and the phase flag.
// ----------------------------------------------------------------------------
interface hcc_req_if;
  import hcc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [TORQUE_W-1:0] torque_left;
  logic signed [TORQUE_W-1:0] torque_right;
  logic        [STIFF_W-1:0]  stiffness_left;
  logic        [STIFF_W-1:0]  stiffness_right;
  logic                       phase_active;

  modport source (
    output valid, torque_left, torque_right, stiffness_left, stiffness_right,
           phase_active,
    input  ready
  );

  modport sink (
    input  valid, torque_left, torque_right, stiffness_left, stiffness_right,
           phase_active,
    output ready
  );
endinterface

@@ src/hcc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Hip compliance result channel
// Valid/ready channel carrying filtered torques and hip corrections.
// ----------------------------------------------------------------------------
interface hcc_rsp_if;
  import hcc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [TORQUE_W-1:0] filtered_left;
  logic signed [TORQUE_W-1:0] filtered_right;
  logic signed [ANGLE_W-1:0]  correction_left;
  logic signed [ANGLE_W-1:0]  correction_right;

  modport source (
    output valid, filtered_left, filtered_right, correction_left,
           correction_right,
    input  ready
  );

  modport sink (
    input  valid, filtered_left, filtered_right, correction_left,
           correction_right,
    output ready
  );
endinterface

@@ src/hip_compliance_correction_top.sv @@
// ----------------------------------------------------------------------------
// Hip compliance correction top level
// Two-lane torque filter and hip angle correction with an output register.
// ----------------------------------------------------------------------------
// Usage:
//   request carries one control tick: left and right hip roll torques
//   (Q15.8), stiffness values (Q16.8) and the phase flag. result returns
//   the filtered torques and the slew-limited hip corrections (Q3.20),
//   exactly one result per request, in order.
//   The configuration port writes filter_alpha, angular_limit and max_step
//   by index; write only while no request is in flight.
// Timing:
//   The left and right lanes run side by side. Each filters the torque
//   (multiply, then sum), starts the divider, runs the serial division (one
//   quotient bit per cycle over the 44-bit dividend), then clamps and slews;
//   the merge and the output register follow. A new request is taken only
//   once the previous result has been loaded into the output register.
// Reset:
//   Clears filter and correction history and the warm-up count, and loads
//   the register defaults. The first WARMUP_TICKS requests bypass the filter.
//   No request is taken while reset is high.
// Stall:
//   A result waits in the output register while the receiver holds ready
//   low; the next request may still be taken and computed meanwhile, then
//   held in the lanes until the output register frees up.
// ----------------------------------------------------------------------------
module hip_compliance_correction_top #(
  parameter int WARMUP_TICKS = hcc_pkg::WARMUP_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  hcc_req_if.sink                           request,
  hcc_rsp_if.source                         result,
  input  logic                              write_enable,
  input  logic [hcc_pkg::CFG_IDX_W-1:0]     reg_index,
  input  logic [hcc_pkg::CFG_DATA_W-1:0]    write_data
);
  import hcc_pkg::*;

  localparam int WARM_W = $clog2(WARMUP_TICKS + 2);

  cfg_t              cfg;
  logic [WARM_W-1:0] warm;
  logic              busy;
  logic              got_left;
  logic              got_right;
  lane_ctl_t         ctl;
  lane_res_t         res_left;
  lane_res_t         res_right;
  logic              take;
  logic              merged;
  logic              load;

  // Accept a new request whenever the lanes are free and reset is low
  assign request.ready = !rst && !busy;
  assign take          = request.valid && request.ready;

  assign ctl.start  = take;
  assign ctl.bypass = warm < WARM_W'(WARMUP_TICKS);
  assign ctl.active = request.phase_active;

  // Register file: drop extra high bits, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha <= ALPHA_RESET;
      cfg.limit <= LIMIT_RESET;
      cfg.step  <= STEP_RESET;
    end else if (write_enable) begin
      unique case (reg_idx_t'(reg_index))
        REG_ALPHA: cfg.alpha <= write_data[ALPHA_W-1:0];
        REG_LIMIT: cfg.limit <= write_data[LIMIT_W-1:0];
        REG_STEP:  cfg.step  <= write_data[LIMIT_W-1:0];
        default:   ;
      endcase
    end
  end

  hcc_lane u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctl       (ctl),
    .torque    (request.torque_left),
    .stiffness (request.stiffness_left),
    .res       (res_left)
  );

  hcc_lane u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctl       (ctl),
    .torque    (request.torque_right),
    .stiffness (request.stiffness_right),
    .res       (res_right)
  );

  // Merge: wait for both lanes, then load the output register when free
  assign merged = got_left && got_right;
  assign load   = merged && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      warm         <= '0;
      busy         <= 1'b0;
      got_left     <= 1'b0;
      got_right    <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        if (ctl.bypass) begin
          warm <= warm + 1'b1;
        end
      end
      if (res_left.done) begin
        got_left <= 1'b1;
      end
      if (res_right.done) begin
        got_right <= 1'b1;
      end
      if (load) begin
        result.valid            <= 1'b1;
        result.filtered_left    <= res_left.filtered;
        result.filtered_right   <= res_right.filtered;
        result.correction_left  <= res_left.correction;
        result.correction_right <= res_right.correction;
        got_left                <= 1'b0;
        got_right               <= 1'b0;
        busy                    <= 1'b0;
      end else if (result.valid && result.ready) begin
        // Drop the result once the receiver takes it
        result.valid <= 1'b0;
      end
    end
  end
endmodule

@@ src/hcc_div.sv @@
// ----------------------------------------------------------------------------
// Hip compliance serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hcc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [hcc_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [hcc_pkg::STIFF_W-1:0]      divisor,
  output logic [hcc_pkg::DIVIDEND_W-1:0]   quotient,
  output logic                             done
);
  import hcc_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [STIFF_W-1:0]    rem;
  logic [STIFF_W-1:0]    dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic [STIFF_W:0]      trial;
  logic                  fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DIVIDEND_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        quotient <= {quotient[DIVIDEND_W-2:0], fits};
        rem      <= fits ? STIFF_W'(trial - {1'b0, dvs}) : trial[STIFF_W-1:0];
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ src/hcc_lane.sv @@
// ----------------------------------------------------------------------------
// Hip compliance lane
// One side: IIR filter, torque over stiffness, clamp and slew limit.
// ----------------------------------------------------------------------------
module hcc_lane (
  input  logic                               clk,
  input  logic                               rst,
  input  hcc_pkg::cfg_t                      cfg,
  input  hcc_pkg::lane_ctl_t                 ctl,
  input  logic signed [hcc_pkg::TORQUE_W-1:0] torque,
  input  logic        [hcc_pkg::STIFF_W-1:0]  stiffness,
  output hcc_pkg::lane_res_t                 res
);
  import hcc_pkg::*;

  localparam int PROD_W = ALPHA_W + TORQUE_W + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT,
    S_SUM,
    S_DIV,
    S_SLEW
  } state_t;

  state_t                     state;
  logic signed [TORQUE_W-1:0] x;
  logic        [STIFF_W-1:0]  stiff;
  logic                       active;
  logic                       bypass;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ANGLE_W-1:0]  target;
  logic                       div_start;

  logic signed [TORQUE_W:0]   diff_f;
  logic signed [PROD_W-1:0]   rounded;
  logic signed [PROD_W-1:0]   f_full;
  logic signed [TORQUE_W-1:0] f_next;
  logic [DIVIDEND_W-1:0]      quotient;
  logic                       div_done;
  logic [LIMIT_W-1:0]         mag;
  logic signed [ANGLE_W:0]    mag_s;
  logic signed [ANGLE_W-1:0]  target_next;
  logic signed [ANGLE_W:0]    last_s;
  logic signed [ANGLE_W:0]    step_s;
  logic signed [ANGLE_W:0]    diff_c;
  logic signed [ANGLE_W:0]    corr_s;

  // Filter: y = x + round(alpha * (prev - x) / 2^16); x on bypass
  assign diff_f  = $signed({res.filtered[TORQUE_W-1], res.filtered})
                 - $signed({x[TORQUE_W-1], x});
  assign rounded = (prod + PROD_W'(32768)) >>> 16;
  assign f_full  = $signed({{(PROD_W-TORQUE_W){x[TORQUE_W-1]}}, x}) + rounded;
  assign f_next  = bypass ? x : f_full[TORQUE_W-1:0];

  // Divider takes the magnitude of the stored filtered torque
  hcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({res.filtered[TORQUE_W-1] ? TORQUE_W'(-res.filtered)
                                         : TORQUE_W'(res.filtered),
                {FRAC_SHIFT{1'b0}}}),
    .divisor  (stiff),
    .quotient (quotient),
    .done     (div_done)
  );

  // Zero stiffness saturates; clamp to limit, sign it; 0 if inactive
  always_comb begin
    if (stiff == '0 || quotient > DIVIDEND_W'(cfg.limit)) begin
      mag = cfg.limit;
    end else begin
      mag = quotient[LIMIT_W-1:0];
    end
    mag_s = $signed({2'b00, mag});
    if (!active || res.filtered == '0) begin
      target_next = '0;
    end else if (res.filtered[TORQUE_W-1]) begin
      target_next = ANGLE_W'(-mag_s);
    end else begin
      target_next = ANGLE_W'(mag_s);
    end
  end

  // Slew limit toward the target
  always_comb begin
    last_s = $signed({res.correction[ANGLE_W-1], res.correction});
    step_s = $signed({2'b00, cfg.step});
    diff_c = $signed({target[ANGLE_W-1], target}) - last_s;
    priority if (diff_c > step_s) begin
      corr_s = last_s + step_s;
    end else if (diff_c < -step_s) begin
      corr_s = last_s - step_s;
    end else begin
      corr_s = $signed({target[ANGLE_W-1], target});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      div_start      <= 1'b0;
      res.done       <= 1'b0;
      res.filtered   <= '0;
      res.correction <= '0;
    end else begin
      div_start <= 1'b0;
      res.done  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctl.start) begin
            x      <= torque;
            stiff  <= stiffness;
            active <= ctl.active;
            bypass <= ctl.bypass;
            state  <= S_FILT;
          end
        end
        S_FILT: begin
          prod  <= $signed({1'b0, cfg.alpha}) * diff_f;
          state <= S_SUM;
        end
        S_SUM: begin
          res.filtered <= f_next;
          div_start    <= 1'b1;
          state        <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            target <= target_next;
            state  <= S_SLEW;
          end
        end
        S_SLEW: begin
          res.correction <= corr_s[ANGLE_W-1:0];
          res.done       <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
